[rtl/core/unsorted_list_table_assert.svh]
// Assertion macros used by the checker file of the list table.
`ifndef UNSORTED_LIST_TABLE_ASSERT_SVH
`define UNSORTED_LIST_TABLE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ULT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ULT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ult_pkg.sv]
// ----------------------------------------------------------------------------
// ult_pkg
// Shared constants and codes of the unsorted list table.
// ----------------------------------------------------------------------------
package ult_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ITEM_WIDTH_DEF = 32;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [VALUE_W-1:0]  t_value;

    localparam t_op OP_INSERT   = 3'd0;
    localparam t_op OP_DELETE   = 3'd1;
    localparam t_op OP_RETRIEVE = 3'd2;
    localparam t_op OP_CLEAR    = 3'd3;
    localparam t_op OP_RESET    = 3'd4;
    localparam t_op OP_NEXT     = 3'd5;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NOTFOUND = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_END      = 2'd3;

endpackage

[rtl/core/unsorted_list_table.sv]
// ----------------------------------------------------------------------------
// unsorted_list_table
// Bounded unsorted list with insert, delete, search, clear and iteration.
// ----------------------------------------------------------------------------
// Input channel i_in_valid/o_in_ready carries one operation and an item value;
// output channel o_out_valid/i_out_ready returns one result per operation:
// status, found flag, iterated item, length and full flag.
// Items sit in a single-port-read, single-port-write memory, oldest at the
// lowest address, so insert is one write. Search walks from the newest entry
// with one shared comparator, reading and then comparing each entry in turn.
// Insert, clear, cursor reset and unknown codes go straight to the result
// stage. Next item reads the memory first. Retrieve reads and compares up to
// DEPTH entries from the newest until a match or the oldest entry; delete does
// the same and then moves each newer entry down one place, with a read and a
// write for each. The block takes one operation at a time; o_in_ready is high
// only while the sequencer is idle.
// A finished result waits in the output register while the next operation
// is accepted; if the receiver stalls, the sequencer holds before its result
// stage until the register frees.
// Reset empties the list and puts the cursor before the first item; the
// memory contents are left as they are.
// ----------------------------------------------------------------------------
module unsorted_list_table #(
    parameter int DEPTH      = ult_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = ult_pkg::ITEM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ult_pkg::t_op                 i_operation,
    input  ult_pkg::t_value              i_item_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ult_pkg::t_status             o_status,
    output logic                         o_found,
    output ult_pkg::t_value              o_item_out,
    output logic [$clog2(DEPTH+1)-1:0]   o_length,
    output logic                         o_full_res
);
    import ult_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_SHRD = 3'd3;
    localparam logic [2:0] S_SHWR = 3'd4;
    localparam logic [2:0] S_NXT  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [ITEM_WIDTH-1:0] r_mem [DEPTH];
    logic [ITEM_WIDTH-1:0] r_rd_data;

    logic [2:0]            r_state, n_state;
    t_op                   r_op, n_op;
    logic [ITEM_WIDTH-1:0] r_val, n_val;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_cursor, n_cursor;
    logic [CW-1:0]         r_idx, n_idx;
    t_status               r_status, n_status;
    logic                  r_found, n_found;
    logic [ITEM_WIDTH-1:0] r_item, n_item;

    logic                  r_out_valid, n_out_valid;
    t_status               r_o_status, n_o_status;
    logic                  r_o_found, n_o_found;
    t_value                r_o_item, n_o_item;
    logic [CW-1:0]         r_o_length, n_o_length;
    logic                  r_o_full, n_o_full;

    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;
    logic                  in_xfer;
    logic [CW-1:0]         nxt_pos;

    assign in_xfer = i_in_valid && (r_state == S_IDLE);
    assign nxt_pos = r_count - r_cursor - CW'(1);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_idx       = r_idx;
        n_status    = r_status;
        n_found     = r_found;
        n_item      = r_item;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_found   = r_o_found;
        n_o_item    = r_o_item;
        n_o_length  = r_o_length;
        n_o_full    = r_o_full;
        rd_en       = 1'b0;
        rd_addr     = r_idx[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_count[AW-1:0];
        wr_data     = r_rd_data;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op     = i_operation;
                    n_val    = ITEM_WIDTH'(i_item_value);
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_item   = '0;
                    n_state  = S_DONE;
                    case (i_operation)
                        OP_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[AW-1:0];
                                wr_data = ITEM_WIDTH'(i_item_value);
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_DELETE, OP_RETRIEVE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                n_idx   = r_count - CW'(1);
                                n_state = S_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_cursor = '0;
                        end
                        OP_RESET: begin
                            n_cursor = '0;
                        end
                        OP_NEXT: begin
                            if (r_cursor >= r_count) begin
                                n_status = ST_END;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = nxt_pos[AW-1:0];
                                n_state = S_NXT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx[AW-1:0];
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_rd_data == r_val) begin
                    n_found = 1'b1;
                    if (r_op == OP_RETRIEVE) begin
                        n_state = S_DONE;
                    end else if (r_idx + CW'(1) == r_count) begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_SHRD;
                    end
                end else if (r_idx == '0) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx - CW'(1);
                    n_state = S_RD;
                end
            end
            S_SHRD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx[AW-1:0];
                n_state = S_SHWR;
            end
            S_SHWR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_idx - CW'(1));
                wr_data = r_rd_data;
                if (r_idx + CW'(1) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SHRD;
                end
            end
            S_NXT: begin
                n_item   = r_rd_data;
                n_cursor = r_cursor + CW'(1);
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_found   = r_found;
                    n_o_item    = VALUE_W'(r_item);
                    n_o_length  = r_count;
                    n_o_full    = (r_count == CW'(DEPTH));
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_found    <= n_found;
        r_item     <= n_item;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_item   <= n_o_item;
        r_o_length <= n_o_length;
        r_o_full   <= n_o_full;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_found     = r_o_found;
    assign o_item_out  = r_o_item;
    assign o_length    = r_o_length;
    assign o_full_res  = r_o_full;

endmodule

[rtl/core/ult_checker.sv]
// ----------------------------------------------------------------------------
// ult_checker
// Port-level checks of the unsorted list table, bound to the top level.
// ----------------------------------------------------------------------------
`include "unsorted_list_table_assert.svh"

module ult_checker #(
    parameter int DEPTH = ult_pkg::DEPTH_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input ult_pkg::t_status           o_status,
    input logic                       o_found,
    input ult_pkg::t_value            o_item_out,
    input logic [$clog2(DEPTH+1)-1:0] o_length,
    input logic                       o_full_res
);
    import ult_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    `ULT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_found) && $stable(o_item_out) && $stable(o_length), "result changed while stalled")
    `ULT_ASSERT_SAME(a_full_len, i_clk, i_rst_n, o_out_valid, (o_full_res == (o_length == CW'(DEPTH))) && (o_length <= CW'(DEPTH)), "full flag or length inconsistent")
    `ULT_ASSERT_SAME(a_found_ok, i_clk, i_rst_n, o_out_valid && o_found, o_status == ST_OK && o_item_out == '0, "found with bad status or item")
    `ULT_ASSERT_SAME(a_err_clean, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, !o_found && o_item_out == '0, "error result carries data")

endmodule

bind unsorted_list_table ult_checker #(.DEPTH(DEPTH)) u_ult_checker (.*);
